FILE: rtl/tpas_pkg.sv
// ---------------------------------------------------------------------------
// tpas_pkg
// Shared types, constants and arithmetic helpers of the action selector.
// ---------------------------------------------------------------------------
package tpas_pkg;

    localparam int NUM_FEATURES_DEF = 128;
    localparam int WEIGHT_BITS_DEF  = 24;

    // fixed field widths
    localparam int ACC_BITS   = 40;
    localparam int WVAL_BITS  = 24;
    localparam int WIDX_BITS  = 8;
    localparam int FIDX_BITS  = 7;
    localparam int BYTE_BITS  = 8;
    localparam int CLS_BITS   = 2;
    localparam int NUM_CLASS  = 3;
    localparam int IN_TDATA_BITS  = 56;
    localparam int OUT_TDATA_BITS = 128;

    localparam logic CMD_WEIGHT  = 1'b0;
    localparam logic CMD_FEATURE = 1'b1;

    localparam logic [CLS_BITS-1:0] CLS_LEFT  = 2'd0;
    localparam logic [CLS_BITS-1:0] CLS_RIGHT = 2'd1;
    localparam logic [CLS_BITS-1:0] CLS_FIRE  = 2'd2;

    typedef enum logic [2:0] {
        ACT_NOOP       = 3'd0,
        ACT_LEFT       = 3'd1,
        ACT_RIGHT      = 3'd2,
        ACT_FIRE       = 3'd3,
        ACT_LEFT_FIRE  = 3'd4,
        ACT_RIGHT_FIRE = 3'd5
    } action_t;

    // stage advance controls shared by the three score lanes
    typedef struct packed {
        logic adv2;   // load product stage
        logic adv3;   // accumulate step
        logic last;   // item in product stage closes the vector
        logic adv4;   // load score stage
    } tpas_ctl_t;

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic signed [ACC_BITS:0] s;
        logic signed [ACC_BITS-1:0] r;
        s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        if (s[ACC_BITS] != s[ACC_BITS-1])
            r = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        else
            r = s[ACC_BITS-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/tpas_weight_mem.sv
// ---------------------------------------------------------------------------
// tpas_weight_mem
// Weight store: one row per slot, one lane per perceptron, lane write,
// one registered read port for feature rows and one for the bias row.
// ---------------------------------------------------------------------------
module tpas_weight_mem
    import tpas_pkg::*;
#(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
    localparam int DEPTH       = NUM_FEATURES + 1,
    localparam int AW          = $clog2(DEPTH)
)
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [CLS_BITS-1:0]               wr_cls,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [WEIGHT_BITS-1:0]            wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic [NUM_CLASS*WEIGHT_BITS-1:0]  rd_row,
    output logic [NUM_CLASS*WEIGHT_BITS-1:0]  bias_row
);

    localparam logic [AW-1:0] BIAS_ADDR = AW'(NUM_FEATURES);

    logic [NUM_CLASS*WEIGHT_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CLASS; c++)
        begin
            if (wr_en && (wr_cls == CLS_BITS'(c)))
                mem[wr_addr][c*WEIGHT_BITS +: WEIGHT_BITS] <= wr_data;
        end
        if (rd_en)
        begin
            rd_row   <= mem[rd_addr];
            bias_row <= mem[BIAS_ADDR];
        end
    end

endmodule

FILE: rtl/tpas_lane.sv
// ---------------------------------------------------------------------------
// tpas_lane
// One perceptron: multiply stage, saturating accumulator, bias completion.
// ---------------------------------------------------------------------------
module tpas_lane
    import tpas_pkg::*;
#(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpas_ctl_t                     ctl,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    input  logic signed [WEIGHT_BITS-1:0] bias,
    input  logic [BYTE_BITS-1:0]          feature,
    output logic signed [ACC_BITS-1:0]    score
);

    localparam logic signed [BYTE_BITS:0] MUL255 = 9'sd255;

    logic signed [WEIGHT_BITS+BYTE_BITS:0] prod_full;
    logic signed [WEIGHT_BITS+BYTE_BITS:0] b255_full;
    logic signed [ACC_BITS-1:0]            prod_reg;
    logic signed [ACC_BITS-1:0]            b255_reg;
    logic signed [ACC_BITS-1:0]            acc_reg;
    logic signed [ACC_BITS-1:0]            acc_sum;
    logic signed [ACC_BITS-1:0]            sum_reg;
    logic signed [ACC_BITS-1:0]            b255_s3_reg;
    logic signed [ACC_BITS-1:0]            score_reg;

    assign prod_full = weight * $signed({1'b0, feature});
    assign b255_full = bias * MUL255;
    assign acc_sum   = sat_add(acc_reg, prod_reg);
    assign score     = score_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv2)
        begin
            prod_reg <= ACC_BITS'(prod_full);
            b255_reg <= ACC_BITS'(b255_full);
        end
        if (ctl.adv3)
        begin
            sum_reg     <= acc_sum;
            b255_s3_reg <= b255_reg;
        end
        if (ctl.adv4)
            score_reg <= sat_add(sum_reg, b255_s3_reg);
    end

    // accumulator restarts after the closing byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ctl.adv3)
            acc_reg <= ctl.last ? '0 : acc_sum;
    end

endmodule

FILE: rtl/three_perceptron_action_selector.sv
// ---------------------------------------------------------------------------
// three_perceptron_action_selector
// Streams feature bytes through three perceptrons and picks an action.
// ---------------------------------------------------------------------------
// Requests carry either a weight write (tuser low) or one feature byte
// (tuser high, tlast on the closing byte). One request is taken every clock
// cycle, writes and bytes alike, as long as the result path is not blocked;
// the only limit is the single write port and the two read ports of the
// weight memory (one row for the byte, one for the bias), each used once per
// request. The result of a vector reaches the output register through registered
// steps: memory read at the edge that took its closing byte, then multiply,
// accumulate, bias completion and decision. The weight memory needs
// no clearing after reset; a weight is to be written before a byte uses it.
module three_perceptron_action_selector
    import tpas_pkg::*;
#(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // class_select, weight_index, weight_value, feature_index, feature_byte
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // command
    input  logic                      s_axis_tuser,
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // action, left_score, right_score, fire_score
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    localparam int DEPTH = NUM_FEATURES + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROW   = NUM_CLASS * WEIGHT_BITS;

    // request fields
    logic [CLS_BITS-1:0]  in_cls;
    logic [WIDX_BITS-1:0] in_widx;
    logic [WVAL_BITS-1:0] in_wval;
    logic [FIDX_BITS-1:0] in_fidx;
    logic [BYTE_BITS-1:0] in_byte;

    assign in_cls  = s_axis_tdata[1:0];
    assign in_widx = s_axis_tdata[9:2];
    assign in_wval = s_axis_tdata[33:10];
    assign in_fidx = s_axis_tdata[40:34];
    assign in_byte = s_axis_tdata[48:41];

    logic go1, go2, go3, go4, go_out;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic last1_reg, last2_reg;
    logic [BYTE_BITS-1:0] x1_reg;
    logic accept, feat_acc, wr_en, in_range;
    logic [AW-1:0] rd_addr;
    logic [ROW-1:0] rd_row, bias_row;
    tpas_ctl_t ctl;

    assign go_out = !out_v_reg || m_axis_tready;
    assign go4    = !v4_reg || go_out;
    assign go3    = !v3_reg || go4;
    assign go2    = !v2_reg || go3;
    assign go1    = !v1_reg || go2;

    assign s_axis_tready = go1;
    assign accept   = s_axis_tvalid && go1;
    assign feat_acc = accept && (s_axis_tuser == CMD_FEATURE);
    assign wr_en    = accept && (s_axis_tuser == CMD_WEIGHT)
                      && (in_cls <= CLS_FIRE) && (int'(in_widx) <= NUM_FEATURES);
    assign in_range = int'(in_fidx) < NUM_FEATURES;
    assign rd_addr  = in_range ? AW'(in_fidx) : '0;

    tpas_weight_mem #(
        .NUM_FEATURES (NUM_FEATURES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_cls   (in_cls),
        .wr_addr  (AW'(in_widx)),
        .wr_data  (WEIGHT_BITS'($signed(in_wval))),
        .rd_en    (feat_acc),
        .rd_addr  (rd_addr),
        .rd_row   (rd_row),
        .bias_row (bias_row)
    );

    assign ctl.adv2 = go2;
    assign ctl.adv3 = v2_reg && go3;
    assign ctl.last = last2_reg;
    assign ctl.adv4 = go4;

    always_ff @(posedge clk)
    begin
        // out-of-range bytes add nothing
        if (go1)
        begin
            x1_reg    <= (s_axis_tuser == CMD_FEATURE && in_range) ? in_byte : '0;
            last1_reg <= s_axis_tlast;
        end
        if (go2)
            last2_reg <= last1_reg;
    end

    logic signed [ACC_BITS-1:0] score [NUM_CLASS];

    for (genvar g = 0; g < NUM_CLASS; g++)
    begin : g_lane
        tpas_lane #(
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .weight  ($signed(rd_row[g*WEIGHT_BITS +: WEIGHT_BITS])),
            .bias    ($signed(bias_row[g*WEIGHT_BITS +: WEIGHT_BITS])),
            .feature (x1_reg),
            .score   (score[g])
        );
    end

    // decision on completed scores
    logic    left_ok, right_ok, fire_ok, left_win, right_win;
    action_t action;

    always_comb
    begin
        left_ok  = !score[0][ACC_BITS-1];
        right_ok = !score[1][ACC_BITS-1];
        fire_ok  = !score[2][ACC_BITS-1];
        left_win  = left_ok;
        right_win = right_ok;
        if (left_ok && right_ok)
        begin
            // ties go left
            if (score[0] >= score[1])
                right_win = 1'b0;
            else
                left_win = 1'b0;
        end
        priority if (fire_ok)
            action = left_win ? ACT_LEFT_FIRE : (right_win ? ACT_RIGHT_FIRE : ACT_FIRE);
        else
            action = left_win ? ACT_LEFT : (right_win ? ACT_RIGHT : ACT_NOOP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (go1)
                v1_reg <= feat_acc;
            if (go2)
                v2_reg <= v1_reg;
            if (go3)
                v3_reg <= v2_reg && last2_reg;
            if (go4)
                v4_reg <= v3_reg;
            if (go_out)
                out_v_reg <= v4_reg;
        end
    end

    logic [OUT_TDATA_BITS-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (go_out)
            out_data_reg <= {(OUT_TDATA_BITS - 3 - 3*ACC_BITS)'(0),
                             score[2], score[1], score[0], action};
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;

    // input stalls only when a result is blocked at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // a new result comes only from a completed score stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(v4_reg))
        else $error("result without completed scores");

    // a left action needs a non-negative left score
    a_left_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] == ACT_LEFT
                           || m_axis_tdata[2:0] == ACT_LEFT_FIRE))
        |-> !m_axis_tdata[3 + ACC_BITS - 1])
        else $error("left chosen with negative left score");

endmodule
